// ----- hw/rtl/cfp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfp_pkg
// widths, codes and beat types shared by the circumcircle pipeline
// ---------------------------------------------------------------------------
package cfp_pkg;

  localparam int CW   = 32;          // coordinate width
  localparam int DW   = CW + 1;      // point offsets
  localparam int PW   = 2 * DW;      // offset products
  localparam int CCW  = PW + 1;      // cross product
  localparam int HW   = PW / 2;      // half of a sum of squares
  localparam int PPW  = DW + HW + 1; // partial product
  localparam int NW   = DW + PW + 1; // numerators
  localparam int DVW  = CCW + 1;     // divisor magnitude |2c|
  localparam int QW   = CW + 3;      // quotient bits kept
  localparam int UW   = QW + 2;      // signed rounded offset
  localparam int XW   = UW + 1;      // center before clamping
  localparam int SW   = 2 * CW + 1;  // u^2 + v^2
  localparam int RW   = 2 * CW + 4;  // root residual

  typedef enum logic [1:0] {
    DIR_COLLINEAR = 2'd0,
    DIR_CCW       = 2'd1,
    DIR_CW        = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_SAT       = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    dir_e                 dir;
    logic                 coll;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [NW-1:0]   nu_mag;
    logic [NW-1:0]   nv_mag;
    logic            u_neg;
    logic            v_neg;
    logic [DVW-1:0]  ad;
  } div_in_t;

  typedef struct packed {
    side_t           side;
    logic [QW-1:0]   qu;
    logic [QW-1:0]   qv;
    logic [DVW-1:0]  ru;
    logic [DVW-1:0]  rv;
    logic [DVW-1:0]  ad;
    logic            u_neg;
    logic            v_neg;
    logic            u_ovf;
    logic            v_ovf;
  } div_out_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    dir_e                 dir;
    logic                 coll;
    logic                 sat;
    logic                 radsat;
  } post_t;

endpackage

// ----- hw/rtl/cfp_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfp_front
// offsets, cross product, sums of squares and the two numerators
// ---------------------------------------------------------------------------
module cfp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [cfp_pkg::CW-1:0] first_x_i,
  input  logic signed [cfp_pkg::CW-1:0] first_y_i,
  input  logic signed [cfp_pkg::CW-1:0] second_x_i,
  input  logic signed [cfp_pkg::CW-1:0] second_y_i,
  input  logic signed [cfp_pkg::CW-1:0] third_x_i,
  input  logic signed [cfp_pkg::CW-1:0] third_y_i,
  output logic                          valid_o,
  output cfp_pkg::div_in_t              div_o
);
  import cfp_pkg::*;

  logic [6:0] vld_q;

  // stage 0: offsets
  logic signed [DW-1:0] x1_0_q, y1_0_q, x2_0_q, y2_0_q;
  logic signed [CW-1:0] px0_q, py0_q, px1_q, py1_q, px2_q, py2_q, px3_q, py3_q;
  logic signed [CW-1:0] px4_q, py4_q, px5_q, py5_q;
  // stage 1: products
  logic signed [DW-1:0] x1_1_q, y1_1_q, x2_1_q, y2_1_q;
  logic signed [PW-1:0] pa_q, pb_q, sx1_q, sy1_q, sx2_q, sy2_q;
  // stage 2: cross product and sums of squares
  logic signed [DW-1:0] x1_2_q, y1_2_q, x2_2_q, y2_2_q;
  logic signed [CCW-1:0] c_q;
  logic [PW-1:0]         a_q, b_q;
  // stage 3: partial products
  logic signed [PPW-1:0] y2al_q, y2ah_q, y1bl_q, y1bh_q;
  logic signed [PPW-1:0] x1bl_q, x1bh_q, x2al_q, x2ah_q;
  logic                  cneg3_q, czero3_q, cneg4_q, czero4_q, cneg5_q, czero5_q;
  logic [DVW-1:0]        ad3_q, ad4_q, ad5_q;
  logic signed [DVW-1:0] twoc;
  // stage 4: full products
  logic signed [NW-1:0]  y2a_q, y1b_q, x1b_q, x2a_q;
  // stage 5: numerators
  logic signed [NW-1:0]  nu_q, nv_q;
  // stage 6: magnitudes
  div_in_t               div_q;

  assign twoc = {c_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x1_0_q <= DW'(second_x_i) - DW'(first_x_i);
    y1_0_q <= DW'(second_y_i) - DW'(first_y_i);
    x2_0_q <= DW'(third_x_i) - DW'(first_x_i);
    y2_0_q <= DW'(third_y_i) - DW'(first_y_i);
    px0_q  <= first_x_i;
    py0_q  <= first_y_i;

    x1_1_q <= x1_0_q;
    y1_1_q <= y1_0_q;
    x2_1_q <= x2_0_q;
    y2_1_q <= y2_0_q;
    pa_q   <= x1_0_q * y2_0_q;
    pb_q   <= x2_0_q * y1_0_q;
    sx1_q  <= x1_0_q * x1_0_q;
    sy1_q  <= y1_0_q * y1_0_q;
    sx2_q  <= x2_0_q * x2_0_q;
    sy2_q  <= y2_0_q * y2_0_q;
    px1_q  <= px0_q;
    py1_q  <= py0_q;

    x1_2_q <= x1_1_q;
    y1_2_q <= y1_1_q;
    x2_2_q <= x2_1_q;
    y2_2_q <= y2_1_q;
    c_q    <= CCW'(pa_q) - CCW'(pb_q);
    a_q    <= $unsigned(sx1_q) + $unsigned(sy1_q);
    b_q    <= $unsigned(sx2_q) + $unsigned(sy2_q);
    px2_q  <= px1_q;
    py2_q  <= py1_q;

    // sums of squares split into two halves for narrow multipliers
    y2al_q   <= y2_2_q * $signed({1'b0, a_q[HW-1:0]});
    y2ah_q   <= y2_2_q * $signed({1'b0, a_q[PW-1:HW]});
    y1bl_q   <= y1_2_q * $signed({1'b0, b_q[HW-1:0]});
    y1bh_q   <= y1_2_q * $signed({1'b0, b_q[PW-1:HW]});
    x1bl_q   <= x1_2_q * $signed({1'b0, b_q[HW-1:0]});
    x1bh_q   <= x1_2_q * $signed({1'b0, b_q[PW-1:HW]});
    x2al_q   <= x2_2_q * $signed({1'b0, a_q[HW-1:0]});
    x2ah_q   <= x2_2_q * $signed({1'b0, a_q[PW-1:HW]});
    cneg3_q  <= c_q[CCW-1];
    czero3_q <= (c_q == '0);
    ad3_q    <= c_q[CCW-1] ? $unsigned(-twoc) : $unsigned(twoc);
    px3_q    <= px2_q;
    py3_q    <= py2_q;

    y2a_q    <= (NW'(y2ah_q) <<< HW) + NW'(y2al_q);
    y1b_q    <= (NW'(y1bh_q) <<< HW) + NW'(y1bl_q);
    x1b_q    <= (NW'(x1bh_q) <<< HW) + NW'(x1bl_q);
    x2a_q    <= (NW'(x2ah_q) <<< HW) + NW'(x2al_q);
    cneg4_q  <= cneg3_q;
    czero4_q <= czero3_q;
    ad4_q    <= ad3_q;
    px4_q    <= px3_q;
    py4_q    <= py3_q;

    nu_q     <= y2a_q - y1b_q;
    nv_q     <= x1b_q - x2a_q;
    cneg5_q  <= cneg4_q;
    czero5_q <= czero4_q;
    ad5_q    <= ad4_q;
    px5_q    <= px4_q;
    py5_q    <= py4_q;

    div_q.nu_mag    <= nu_q[NW-1] ? $unsigned(-nu_q) : $unsigned(nu_q);
    div_q.nv_mag    <= nv_q[NW-1] ? $unsigned(-nv_q) : $unsigned(nv_q);
    div_q.u_neg     <= nu_q[NW-1] ^ cneg5_q;
    div_q.v_neg     <= nv_q[NW-1] ^ cneg5_q;
    div_q.ad        <= ad5_q;
    div_q.side.px   <= px5_q;
    div_q.side.py   <= py5_q;
    div_q.side.coll <= czero5_q;
    div_q.side.dir  <= czero5_q ? DIR_COLLINEAR : (cneg5_q ? DIR_CW : DIR_CCW);
  end

  assign valid_o = vld_q[6];
  assign div_o   = div_q;

endmodule

// ----- hw/rtl/cfp_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfp_div
// two-lane restoring divider, one quotient bit per stage, shared divisor
// ---------------------------------------------------------------------------
module cfp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cfp_pkg::div_in_t  div_i,
  output logic              valid_o,
  output cfp_pkg::div_out_t div_o
);
  import cfp_pkg::*;

  typedef struct packed {
    side_t          side;
    logic [DVW-1:0] ad;
    logic [DVW-1:0] ru;
    logic [DVW-1:0] rv;
    logic [QW-1:0]  lu;
    logic [QW-1:0]  lv;
    logic [QW-1:0]  qu;
    logic [QW-1:0]  qv;
    logic           u_neg;
    logic           v_neg;
    logic           u_ovf;
    logic           v_ovf;
  } dst_t;

  logic [QW:0] vld_q;
  dst_t        st_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  // quotient wider than kept bits is flagged, the rest starts the long division
  always_ff @(posedge clk_i) begin
    st_q[0].side  <= div_i.side;
    st_q[0].ad    <= div_i.ad;
    st_q[0].u_neg <= div_i.u_neg;
    st_q[0].v_neg <= div_i.v_neg;
    st_q[0].u_ovf <= (DVW+QW)'(div_i.nu_mag) >= {div_i.ad, {QW{1'b0}}};
    st_q[0].v_ovf <= (DVW+QW)'(div_i.nv_mag) >= {div_i.ad, {QW{1'b0}}};
    st_q[0].ru    <= DVW'(div_i.nu_mag >> QW);
    st_q[0].rv    <= DVW'(div_i.nv_mag >> QW);
    st_q[0].lu    <= div_i.nu_mag[QW-1:0];
    st_q[0].lv    <= div_i.nv_mag[QW-1:0];
    st_q[0].qu    <= '0;
    st_q[0].qv    <= '0;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [DVW:0] tu, tv;
    logic         geu, gev;

    assign tu  = {st_q[i-1].ru, st_q[i-1].lu[QW-1]};
    assign tv  = {st_q[i-1].rv, st_q[i-1].lv[QW-1]};
    assign geu = tu >= {1'b0, st_q[i-1].ad};
    assign gev = tv >= {1'b0, st_q[i-1].ad};

    always_ff @(posedge clk_i) begin
      st_q[i].side  <= st_q[i-1].side;
      st_q[i].ad    <= st_q[i-1].ad;
      st_q[i].u_neg <= st_q[i-1].u_neg;
      st_q[i].v_neg <= st_q[i-1].v_neg;
      st_q[i].u_ovf <= st_q[i-1].u_ovf;
      st_q[i].v_ovf <= st_q[i-1].v_ovf;
      st_q[i].ru    <= geu ? DVW'(tu - {1'b0, st_q[i-1].ad}) : DVW'(tu);
      st_q[i].rv    <= gev ? DVW'(tv - {1'b0, st_q[i-1].ad}) : DVW'(tv);
      st_q[i].lu    <= st_q[i-1].lu << 1;
      st_q[i].lv    <= st_q[i-1].lv << 1;
      st_q[i].qu    <= {st_q[i-1].qu[QW-2:0], geu};
      st_q[i].qv    <= {st_q[i-1].qv[QW-2:0], gev};
    end
  end

  assign valid_o     = vld_q[QW];
  assign div_o.side  = st_q[QW].side;
  assign div_o.qu    = st_q[QW].qu;
  assign div_o.qv    = st_q[QW].qv;
  assign div_o.ru    = st_q[QW].ru;
  assign div_o.rv    = st_q[QW].rv;
  assign div_o.ad    = st_q[QW].ad;
  assign div_o.u_neg = st_q[QW].u_neg;
  assign div_o.v_neg = st_q[QW].v_neg;
  assign div_o.u_ovf = st_q[QW].u_ovf;
  assign div_o.v_ovf = st_q[QW].v_ovf;

endmodule

// ----- hw/rtl/cfp_sqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfp_sqrt
// pipelined integer square root, one root bit per stage
// ---------------------------------------------------------------------------
module cfp_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [cfp_pkg::SW-1:0] s_i,
  input  cfp_pkg::post_t       side_i,
  output logic                 valid_o,
  output logic [cfp_pkg::CW:0] root_o,
  output cfp_pkg::post_t       side_o
);
  import cfp_pkg::*;

  typedef struct packed {
    logic [RW-1:0] res;
    logic [CW:0]   root;
    post_t         side;
  } sst_t;

  logic [CW:0] vld_q;
  sst_t        st_q [CW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CW-1:0], valid_i};
    end
  end

  for (genvar j = 0; j <= CW; j++) begin : g_stage
    localparam int B = CW - j;
    sst_t          prev;
    logic [RW-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign prev.res  = RW'(s_i);
      assign prev.root = '0;
      assign prev.side = side_i;
    end else begin : g_next
      assign prev = st_q[j-1];
    end

    // (root + 2^B)^2 - root^2 with root clear below bit B+1
    assign trial = (RW'(prev.root) << (B + 1)) | (RW'(1) << (2 * B));
    assign ge    = prev.res >= trial;

    always_ff @(posedge clk_i) begin
      st_q[j].res  <= ge ? prev.res - trial : prev.res;
      st_q[j].root <= ge ? (prev.root | ((CW+1)'(1) << B)) : prev.root;
      st_q[j].side <= prev.side;
    end
  end

  assign valid_o = vld_q[CW];
  assign root_o  = st_q[CW].root;
  assign side_o  = st_q[CW].side;

endmodule

// ----- hw/rtl/circle_from_three_points.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circle_from_three_points
// circumcircle of three signed fixed-point points: center, radius, direction
// ---------------------------------------------------------------------------
// A beat is taken at every clock edge with start high; busy is always low,
// so one point triple can enter each cycle. Each result leaves on done_o
// for one cycle, in order, and must be taken then. The path runs through
// two long pipelines: a divider of 36 stages that resolves one quotient
// bit per stage after its first, and a square root that resolves one root
// bit per stage (33 stages), plus 7 front stages, 4 round and clamp stages
// and the output register.
// ---------------------------------------------------------------------------
module circle_from_three_points (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [cfp_pkg::CW-1:0] first_x_i,
  input  logic signed [cfp_pkg::CW-1:0] first_y_i,
  input  logic signed [cfp_pkg::CW-1:0] second_x_i,
  input  logic signed [cfp_pkg::CW-1:0] second_y_i,
  input  logic signed [cfp_pkg::CW-1:0] third_x_i,
  input  logic signed [cfp_pkg::CW-1:0] third_y_i,
  output logic                          done_o,
  output logic signed [cfp_pkg::CW-1:0] ctr_x_o,
  output logic signed [cfp_pkg::CW-1:0] ctr_y_o,
  output logic [cfp_pkg::CW-1:0]        radius_o,
  output logic [1:0]                    direction_o,
  output logic [1:0]                    status_o
);
  import cfp_pkg::*;

  localparam logic signed [XW-1:0] CX_HI = XW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [XW-1:0] CX_LO = -CX_HI - XW'(1);
  localparam logic [QW:0]          Q_MAX = (QW+1)'({CW{1'b1}});

  // front end and divider
  logic      fr_valid, dv_valid;
  div_in_t   fr_out;
  div_out_t  dv_out;

  cfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .third_x_i  (third_x_i),
    .third_y_i  (third_y_i),
    .valid_o    (fr_valid),
    .div_o      (fr_out)
  );

  cfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .div_i   (fr_out),
    .valid_o (dv_valid),
    .div_o   (dv_out)
  );

  logic [3:0] vld_q;

  // round stage: nearest, ties away from zero (applied to the magnitude)
  logic [QW:0]    qru_q, qrv_q;
  logic           uneg1_q, vneg1_q, uovf1_q, vovf1_q;
  side_t          side1_q;

  // sign stage
  logic signed [UW-1:0] u2_q, v2_q;
  logic [UW-1:0]        umag, vmag;
  logic [CW-1:0]        um2_q, vm2_q;
  logic                 ubig2_q, vbig2_q;
  side_t                side2_q;

  // clamp and square stage
  logic signed [XW-1:0] cx_sum, cy_sum;
  logic signed [CW-1:0] cx3_q, cy3_q;
  logic                 sat3_q, radsat3_q;
  logic [2*CW-1:0]      usq3_q, vsq3_q;
  side_t                side3_q;

  // sum of squares, feeds the root
  logic [SW-1:0]        s4_q;
  post_t                post4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], dv_valid};
    end
  end

  // huge quotients are pinned past the clamp bound so the center saturates
  assign umag = uovf1_q ? (UW'(1) << QW) : UW'(qru_q);
  assign vmag = vovf1_q ? (UW'(1) << QW) : UW'(qrv_q);

  assign cx_sum = XW'(u2_q) + XW'(side2_q.px);
  assign cy_sum = XW'(v2_q) + XW'(side2_q.py);

  always_ff @(posedge clk_i) begin
    qru_q   <= (QW+1)'(dv_out.qu) + (QW+1)'({dv_out.ru, 1'b0} >= {1'b0, dv_out.ad});
    qrv_q   <= (QW+1)'(dv_out.qv) + (QW+1)'({dv_out.rv, 1'b0} >= {1'b0, dv_out.ad});
    uneg1_q <= dv_out.u_neg;
    vneg1_q <= dv_out.v_neg;
    uovf1_q <= dv_out.u_ovf;
    vovf1_q <= dv_out.v_ovf;
    side1_q <= dv_out.side;

    u2_q    <= uneg1_q ? -$signed(umag) : $signed(umag);
    v2_q    <= vneg1_q ? -$signed(vmag) : $signed(vmag);
    um2_q   <= qru_q[CW-1:0];
    vm2_q   <= qrv_q[CW-1:0];
    ubig2_q <= uovf1_q | (qru_q > Q_MAX);
    vbig2_q <= vovf1_q | (qrv_q > Q_MAX);
    side2_q <= side1_q;

    if (cx_sum > CX_HI) begin
      cx3_q <= CX_HI[CW-1:0];
    end else if (cx_sum < CX_LO) begin
      cx3_q <= CX_LO[CW-1:0];
    end else begin
      cx3_q <= cx_sum[CW-1:0];
    end
    if (cy_sum > CX_HI) begin
      cy3_q <= CX_HI[CW-1:0];
    end else if (cy_sum < CX_LO) begin
      cy3_q <= CX_LO[CW-1:0];
    end else begin
      cy3_q <= cy_sum[CW-1:0];
    end
    sat3_q    <= (cx_sum > CX_HI) | (cx_sum < CX_LO) | (cy_sum > CX_HI) | (cy_sum < CX_LO);
    radsat3_q <= ubig2_q | vbig2_q;
    usq3_q    <= um2_q * um2_q;
    vsq3_q    <= vm2_q * vm2_q;
    side3_q   <= side2_q;

    s4_q           <= SW'(usq3_q) + SW'(vsq3_q);
    post4_q.cx     <= cx3_q;
    post4_q.cy     <= cy3_q;
    post4_q.dir    <= side3_q.dir;
    post4_q.coll   <= side3_q.coll;
    post4_q.sat    <= sat3_q;
    post4_q.radsat <= radsat3_q;
  end

  // square root of u^2 + v^2
  logic          sq_valid;
  logic [CW:0]   sq_root;
  post_t         sq_side;

  cfp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[3]),
    .s_i     (s4_q),
    .side_i  (post4_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // output register
  logic                 done_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [CW-1:0]        rad_q;
  dir_e                 dir_q;
  status_e              st_q;
  logic                 rad_over;

  assign rad_over = sq_side.radsat | sq_root[CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_side.coll) begin
      // collinear or coincident points: no circle
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= '0;
      dir_q <= DIR_COLLINEAR;
      st_q  <= ST_COLLINEAR;
    end else begin
      cx_q  <= sq_side.cx;
      cy_q  <= sq_side.cy;
      rad_q <= rad_over ? {CW{1'b1}} : sq_root[CW-1:0];
      dir_q <= sq_side.dir;
      st_q  <= (sq_side.sat | rad_over) ? ST_SAT : ST_OK;
    end
  end

  assign busy        = 1'b0;
  assign done_o      = done_q;
  assign ctr_x_o     = cx_q;
  assign ctr_y_o     = cy_q;
  assign radius_o    = rad_q;
  assign direction_o = dir_q;
  assign status_o    = st_q;

endmodule

// ----- tb/sv/circle_from_three_points_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circle_from_three_points_tb
// self-checking bench for the circumcircle pipeline: directed corner triples
// followed by random triples, each result checked against an exact predictor
// ---------------------------------------------------------------------------
module circle_from_three_points_tb;
  import cfp_pkg::*;

  localparam int LATENCY = 81;
  localparam int N_RANDOM = 1200;

  // wide signed arithmetic for the exact predictor
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by, qx, qy;
  } triple_t;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [CW-1:0]        rad;
    dir_e                 dir;
    status_e              st;
  } circle_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] first_x_i = '0, first_y_i = '0, second_x_i = '0;
  logic signed [CW-1:0] second_y_i = '0, third_x_i = '0, third_y_i = '0;
  logic done_o;
  logic signed [CW-1:0] ctr_x_o, ctr_y_o;
  logic [CW-1:0] radius_o;
  logic [1:0] direction_o, status_o;

  triple_t pending_triples[$];
  circle_t expected_circles[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_collinear = 0;
  int n_saturated = 0;
  bit stimulus_done = 1'b0;

  circle_from_three_points dut (
    .clk_i, .rst_ni, .start, .busy,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i, .third_x_i, .third_y_i,
    .done_o, .ctr_x_o, .ctr_y_o, .radius_o, .direction_o, .status_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // divide with rounding to nearest, ties away from zero
  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t an, ad, q, r;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = an / ad;
    r = an % ad;
    if (2 * r >= ad) q = q + 1;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(wide_t a, ref bit sat);
    wide_t lo, hi;
    lo = -(wide_t'(1) <<< (CW - 1));
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    if (a < lo) begin
      sat = 1'b1;
      return lo[CW-1:0];
    end
    if (a > hi) begin
      sat = 1'b1;
      return hi[CW-1:0];
    end
    return a[CW-1:0];
  endfunction

  function automatic circle_t circumcircle(triple_t t);
    circle_t o;
    wide_t x1, y1, x2, y2, c, a2, b2, u, v, lim, s, rad, trial;
    bit sat;
    sat = 1'b0;
    x1 = wide_t'(t.bx) - wide_t'(t.ax);
    y1 = wide_t'(t.by) - wide_t'(t.ay);
    x2 = wide_t'(t.qx) - wide_t'(t.ax);
    y2 = wide_t'(t.qy) - wide_t'(t.ay);
    c = x1 * y2 - x2 * y1;
    if (c == 0) begin
      o.cx = '0;
      o.cy = '0;
      o.rad = '0;
      o.dir = DIR_COLLINEAR;
      o.st = ST_COLLINEAR;
      return o;
    end
    a2 = x1 * x1 + y1 * y1;
    b2 = x2 * x2 + y2 * y2;
    u = div_round(y2 * a2 - y1 * b2, 2 * c);
    v = div_round(x1 * b2 - x2 * a2, 2 * c);
    o.cx = clamp_coord(u + wide_t'(t.ax), sat);
    o.cy = clamp_coord(v + wide_t'(t.ay), sat);
    lim = (wide_t'(1) <<< CW) - 1;
    if ((u < 0 ? -u : u) > lim || (v < 0 ? -v : v) > lim) begin
      rad = lim;
      sat = 1'b1;
    end else begin
      // bitwise integer square root
      s = u * u + v * v;
      rad = 0;
      for (int b = CW; b >= 0; b--) begin
        trial = rad | (wide_t'(1) <<< b);
        if (trial * trial <= s) rad = trial;
      end
      if (rad > lim) begin
        rad = lim;
        sat = 1'b1;
      end
    end
    o.rad = rad[CW-1:0];
    o.dir = (c < 0) ? DIR_CW : DIR_CCW;
    o.st = sat ? ST_SAT : ST_OK;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    n_errors++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * 65536 * 100)) - 65536 * 100;
      2: return $signed($urandom_range(0, 64)) - 32;
      default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff - $urandom_range(0, 3)
                                              : 32'sh80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic push_triple(logic signed [CW-1:0] ax, ay, bx, by, qx, qy);
    triple_t t;
    t.ax = ax; t.ay = ay; t.bx = bx; t.by = by; t.qx = qx; t.qy = qy;
    pending_triples.push_back(t);
  endtask

  // stimulus: directed corners, then random triples
  initial begin
    triple_t t;
    int mode;
    logic signed [CW-1:0] dx, dy, k;
    // unit right triangle, both turning directions
    push_triple(0, 0, 32'sh10000, 0, 0, 32'sh10000);
    push_triple(0, 0, 0, 32'sh10000, 32'sh10000, 0);
    // coincident points and a collinear line
    push_triple(5, 5, 5, 5, 5, 5);
    push_triple(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000);
    push_triple(1, 2, 1, 2, 7, 9);
    // extreme coordinates, center and radius saturating
    push_triple(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh80000000, 32'sh7fffffff);
    push_triple(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff, 32'sh80000000);
    push_triple(32'sh80000000, 0, 32'sh7fffffff, 0, 0, 1);
    push_triple(0, 0, 1, 0, 32'sh7fffffff, 32'sh7fffffff);
    push_triple(0, 0, 1, 0, 32'sh80000000, 1);
    // tiny triangles exercise rounding ties
    push_triple(0, 0, 1, 0, 0, 1);
    push_triple(0, 0, 3, 0, 0, -1);
    push_triple(-1, -1, 2, 1, -3, 4);
    push_triple(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh0, 32'sh12345678,
                32'shedcba987);
    push_triple(32'sh0, 32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'shedcba987,
                32'sh12345678);
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        t.ax = rand_coord(0); t.ay = rand_coord(0);
        t.bx = rand_coord(0); t.by = rand_coord(0);
        t.qx = rand_coord(0); t.qy = rand_coord(0);
      end else if (mode < 7) begin
        t.ax = rand_coord(1); t.ay = rand_coord(1);
        t.bx = rand_coord(1); t.by = rand_coord(1);
        t.qx = rand_coord(1); t.qy = rand_coord(1);
      end else if (mode < 8) begin
        t.ax = rand_coord(2); t.ay = rand_coord(2);
        t.bx = rand_coord(2); t.by = rand_coord(2);
        t.qx = rand_coord(2); t.qy = rand_coord(2);
      end else if (mode < 9) begin
        // collinear: third point is a multiple of the second's offset
        t.ax = rand_coord(1); t.ay = rand_coord(1);
        dx = rand_coord(2); dy = rand_coord(2);
        k = $signed($urandom_range(0, 6)) - 3;
        t.bx = t.ax + dx; t.by = t.ay + dy;
        t.qx = t.ax + k * dx; t.qy = t.ay + k * dy;
      end else begin
        t.ax = rand_coord(3); t.ay = rand_coord(1);
        t.bx = rand_coord(3); t.by = rand_coord(3);
        t.qx = rand_coord(1); t.qy = rand_coord(3);
      end
      pending_triples.push_back(t);
    end
  end

  // driver: holds start high across back-to-back beats, drops it for gaps
  int drive_gap = 0;
  triple_t cur;
  bit cur_valid = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // a beat offered last cycle was taken at the rising edge if busy was low
      if (cur_valid && start && !busy) begin
        expected_circles.push_back(circumcircle(cur));
        cur_valid = 1'b0;
        if ($urandom_range(0, 3) == 0) drive_gap = gap_length();
      end
      if (!cur_valid && drive_gap == 0 && pending_triples.size() > 0) begin
        cur = pending_triples.pop_front();
        cur_valid = 1'b1;
      end
      if (drive_gap > 0) drive_gap--;
      if (cur_valid) begin
        first_x_i <= cur.ax;
        first_y_i <= cur.ay;
        second_x_i <= cur.bx;
        second_y_i <= cur.by;
        third_x_i <= cur.qx;
        third_y_i <= cur.qy;
      end
      start <= cur_valid;
      if (!cur_valid && pending_triples.size() == 0) stimulus_done = 1'b1;
    end
  end

  // monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk_i) begin
    circle_t want;
    if (rst_ni && done_o) begin
      if (expected_circles.size() == 0) begin
        n_errors++;
        $display("unexpected result at %0t", $realtime);
      end else begin
        want = expected_circles.pop_front();
        n_checked++;
        if (want.st == ST_COLLINEAR) n_collinear++;
        if (want.st == ST_SAT) n_saturated++;
        if (ctr_x_o !== want.cx) report_mismatch("ctr_x", ctr_x_o, want.cx);
        if (ctr_y_o !== want.cy) report_mismatch("ctr_y", ctr_y_o, want.cy);
        if (radius_o !== want.rad) report_mismatch("radius", radius_o, want.rad);
        if (direction_o !== want.dir) begin
          report_mismatch("direction", CW'(direction_o), CW'(want.dir));
        end
        if (status_o !== want.st) begin
          report_mismatch("status", CW'(status_o), CW'(want.st));
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done);
    wait (expected_circles.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("checked %0d circles, %0d collinear and %0d saturated", n_checked,
             n_collinear, n_saturated);
    if (n_errors == 0 && expected_circles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_div.sv
hw/rtl/cfp_sqrt.sv
hw/rtl/circle_from_three_points.sv
tb/sv/circle_from_three_points_tb.sv
